/* rtl/cbs_pkg.sv */
// Shared constants, widths, rounding helpers and controller/datapath
// interface structs for the cubic Bezier sampler. No dependencies.
`default_nettype none

package cbs_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int T_FRAC_BITS = 16;

  localparam int COORD_W    = 32;
  localparam int NUM_COORDS = 8;
  localparam int NUM_W      = 7;
  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 64;

  // sample counter and divisor width, able to hold MAX_POINTS itself
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (NUM_W > CNT_W) ? NUM_W : CNT_W;

  // t and s range over 0 .. 1.0, one integer bit
  localparam int TW    = T_FRAC_BITS + 1;
  localparam int SQ_W  = 2 * TW;
  // weights carry the factor of three
  localparam int WW    = TW + 2;
  localparam int PW    = COORD_W + WW + 1;
  localparam int TM_W  = PW - T_FRAC_BITS;
  localparam int AW    = TM_W + 2;

  localparam int DIV_STEPS = TW;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TW-1:0] ONE_T  = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0] HALF_T = TW'(1) << (T_FRAC_BITS - 1);

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             issue;
    logic             last;
    logic [CNT_W-1:0] seg_d;
  } cbs_cmd_t;

  typedef struct packed {
    logic adv;
    logic pipe_busy;
  } cbs_stat_t;

  // unsigned product rounded to nearest back to T_FRAC_BITS fraction bits
  function automatic logic [TW-1:0] rnd_mul_u(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
    logic [SQ_W-1:0] p;
    p = a * b + SQ_W'(HALF_T);
    return p[T_FRAC_BITS +: TW];
  endfunction

  function automatic logic signed [PW-1:0] mul_cw(input logic signed [COORD_W-1:0] c,
                                                  input logic [WW-1:0] w);
    logic signed [WW:0] ws;
    ws = $signed({1'b0, w});
    return c * ws;
  endfunction

  // floor((p + half) / 2^F)
  function automatic logic signed [TM_W-1:0] rnd_s(input logic signed [PW-1:0] p);
    logic [PW-1:0] q;
    q = p + PW'(HALF_T);
    return $signed(q[PW-1:T_FRAC_BITS]);
  endfunction

  function automatic logic [COORD_W-1:0] sat32(input logic signed [AW-1:0] a);
    logic hi_same;
    hi_same = (a[AW-1:COORD_W-1] == {(AW-COORD_W+1){1'b0}}) ||
              (a[AW-1:COORD_W-1] == {(AW-COORD_W+1){1'b1}});
    if (hi_same) begin
      return a[COORD_W-1:0];
    end else if (a[AW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/cbs_ctrl.sv */
// Sequencer for the cubic Bezier sampler: input acceptance, reciprocal
// setup steps and per-sample issue. Depends on cbs_pkg.
`default_nettype none

module cbs_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [cbs_pkg::NUM_W-1:0] num_points,
  input  cbs_pkg::cbs_stat_t      stat,
  output cbs_pkg::cbs_cmd_t       cmd
);
  import cbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } cbs_state_t;

  cbs_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [DIV_CNT_W-1:0] divcnt_r, divcnt_nxt;
  logic [CMP_W-1:0]     num_ext;
  logic [CNT_W-1:0]     n_sat;
  logic                 accept;
  logic                 is_last;

  always_comb begin
    num_ext = CMP_W'(num_points);
    n_sat   = (num_ext > CMP_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : num_ext[CNT_W-1:0];
    in_ready = (state_r == ST_IDLE) && !stat.pipe_busy;
    accept   = in_valid && in_ready;
    is_last  = (idx_r == (total_r - CNT_W'(1)));

    cmd.load     = accept;
    cmd.seg_d    = n_sat - CNT_W'(1);
    cmd.div_step = (state_r == ST_DIV);
    cmd.issue    = (state_r == ST_RUN) && stat.adv;
    cmd.last     = is_last;

    state_nxt  = state_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    divcnt_nxt = divcnt_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          total_nxt  = n_sat;
          idx_nxt    = '0;
          divcnt_nxt = '0;
          if (n_sat == CNT_W'(0)) begin
            state_nxt = ST_IDLE;
          end else if (n_sat == CNT_W'(1)) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        divcnt_nxt = divcnt_r + DIV_CNT_W'(1);
        if (divcnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.adv) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      total_r  <= '0;
      divcnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      total_r  <= total_nxt;
      divcnt_r <= divcnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/cbs_dp.sv */
// Datapath of the cubic Bezier sampler: held control points, step divider,
// t stepper and the stalling weight/product/sum pipeline. Depends on cbs_pkg.
`default_nettype none

module cbs_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cbs_pkg::IN_DATA_W-1:0] in_data,
  input  cbs_pkg::cbs_cmd_t           cmd,
  output cbs_pkg::cbs_stat_t          stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [cbs_pkg::COORD_W-1:0] out_x,
  output logic [cbs_pkg::COORD_W-1:0] out_y,
  output logic                        out_last
);
  import cbs_pkg::*;

  logic signed [COORD_W-1:0] coord_r [NUM_COORDS];

  // step divider: 2^F / d gives quotient and remainder
  logic [CNT_W-1:0] d_r;
  logic [CNT_W-1:0] div_rem_r;
  logic [TW-1:0]    div_quo_r;
  logic [CNT_W:0]   div_trial;
  logic [CNT_W:0]   div_diff;
  logic             div_ge;

  // t stepper: t = floor((i*2^F + d/2) / d) kept as quotient and remainder
  logic [TW-1:0]    step_q_r;
  logic [CNT_W-1:0] step_r_r;
  logic [CNT_W:0]   step_sum;
  logic [CNT_W:0]   step_diff;
  logic             step_wrap;

  logic adv;

  logic          v0_r, v1_r, v2_r, v3_r, v4_r, outv_r;
  logic          last0_r, last1_r, last2_r, last3_r, last4_r, outlast_r;
  logic [TW-1:0] t0_r, s0_r;
  logic [TW-1:0] t1_r, s1_r, ssq1_r, tsq1_r;
  logic [WW-1:0] w2_r [4];
  logic signed [PW-1:0]   prod3_r [NUM_COORDS];
  logic signed [TM_W-1:0] term4_r [NUM_COORDS];
  logic [COORD_W-1:0]     outx_r, outy_r;

  logic [TW-1:0] m0, m1, m2, m3;
  logic signed [AW-1:0] acc_x, acc_y;

  always_comb begin
    div_trial = {div_rem_r, div_quo_r[TW-1]};
    div_ge    = div_trial >= {1'b0, d_r};
    div_diff  = div_trial - {1'b0, d_r};

    step_sum  = {1'b0, step_r_r} + {1'b0, div_rem_r};
    step_wrap = step_sum >= {1'b0, d_r};
    step_diff = step_sum - {1'b0, d_r};

    adv            = !outv_r || out_ready;
    stat.adv       = adv;
    stat.pipe_busy = v0_r || v1_r || v2_r;

    m0 = rnd_mul_u(ssq1_r, s1_r);
    m1 = rnd_mul_u(ssq1_r, t1_r);
    m2 = rnd_mul_u(s1_r, tsq1_r);
    m3 = rnd_mul_u(tsq1_r, t1_r);

    acc_x = '0;
    acc_y = '0;
    for (int p = 0; p < 4; p++) begin
      acc_x = acc_x + AW'(term4_r[2 * p]);
      acc_y = acc_y + AW'(term4_r[2 * p + 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < NUM_COORDS; k++) begin
        coord_r[k] <= $signed(in_data[COORD_W * k +: COORD_W]);
      end
      d_r       <= cmd.seg_d;
      div_rem_r <= '0;
      div_quo_r <= ONE_T;
      step_q_r  <= '0;
      step_r_r  <= cmd.seg_d >> 1;
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
      div_quo_r <= {div_quo_r[TW-2:0], div_ge};
    end else if (cmd.issue) begin
      step_q_r <= step_q_r + div_quo_r + TW'(step_wrap);
      step_r_r <= step_wrap ? step_diff[CNT_W-1:0] : step_sum[CNT_W-1:0];
    end
  end

  // pipeline valid bits, all advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      outv_r <= 1'b0;
    end else if (adv) begin
      v0_r   <= cmd.issue;
      v1_r   <= v0_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      outv_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r    <= step_q_r;
      s0_r    <= ONE_T - step_q_r;
      last0_r <= cmd.last;

      t1_r    <= t0_r;
      s1_r    <= s0_r;
      ssq1_r  <= rnd_mul_u(s0_r, s0_r);
      tsq1_r  <= rnd_mul_u(t0_r, t0_r);
      last1_r <= last0_r;

      w2_r[0] <= WW'(m0);
      w2_r[1] <= WW'({m1, 1'b0}) + WW'(m1);
      w2_r[2] <= WW'({m2, 1'b0}) + WW'(m2);
      w2_r[3] <= WW'(m3);
      last2_r <= last1_r;

      for (int k = 0; k < NUM_COORDS; k++) begin
        prod3_r[k] <= mul_cw(coord_r[k], w2_r[k / 2]);
      end
      last3_r <= last2_r;

      for (int k = 0; k < NUM_COORDS; k++) begin
        term4_r[k] <= rnd_s(prod3_r[k]);
      end
      last4_r <= last3_r;

      outx_r    <= sat32(acc_x);
      outy_r    <= sat32(acc_y);
      outlast_r <= last4_r;
    end
  end

  assign out_valid = outv_r;
  assign out_x     = outx_r;
  assign out_y     = outy_r;
  assign out_last  = outlast_r;

endmodule

`default_nettype wire

/* rtl/cubic_bezier_sampler.sv */
// Cubic Bezier sampler, top level: joins the sequencer and the datapath.
// The first point of a segment passes a restoring divide of 2^F by N-1,
// skipped for N = 1, then the 6-stage weight pipeline. One point per cycle
// while the output is not stalled; a new segment is taken only once the
// last point of the previous one has been issued and has left the weight
// stages reading the held points. Reset (rst_n low, synchronous) empties
// the pipeline and returns the sequencer to idle.
`default_nettype none

module cubic_bezier_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y,
  // num_points, zero pad
  input  logic [cbs_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_x, out_y
  output logic [cbs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import cbs_pkg::*;

  cbs_cmd_t           cmd;
  cbs_stat_t          stat;
  logic [COORD_W-1:0] pt_x, pt_y;

  cbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .num_points (in_tdata[NUM_COORDS * COORD_W +: NUM_W]),
    .stat       (stat),
    .cmd        (cmd)
  );

  cbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_x     (pt_x),
    .out_y     (pt_y),
    .out_last  (out_tlast)
  );

  assign out_tdata = {pt_y, pt_x};

endmodule

`default_nettype wire

/* dv/cubic_bezier_sampler_tb.sv */
// Self-checking testbench for cubic_bezier_sampler: drives curve segments on the
// input stream, predicts every sampled point and checks the output stream.
// Depends on cbs_pkg and the cubic_bezier_sampler RTL.
`timescale 1ns / 100ps

module cubic_bezier_sampler_tb;
  import cbs_pkg::*;

  localparam int     STALL_LIMIT = 4000;
  localparam int     LONG_HOLD   = 400;
  localparam int     DRAIN_WAIT  = 40;
  localparam int     RAND_ITEMS  = 355;
  localparam longint ONE_FIX     = longint'(1) << T_FRAC_BITS;
  localparam longint HALF_FIX    = longint'(1) << (T_FRAC_BITS - 1);

  // pt[0] = ctrl0_x, pt[1] = ctrl0_y, ... pt[7] = ctrl3_y
  typedef struct packed {
    logic [NUM_W-1:0]          n;
    logic [7:0][COORD_W-1:0]   pt;
  } segment_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } curve_point_t;

  class curve_point_tracker;
    curve_point_t pending_points[$];
    int           mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function longint round_frac(longint v);
      return (v + HALF_FIX) >>> T_FRAC_BITS;
    endfunction

    static function logic [COORD_W-1:0] sample_axis(segment_t seg, longint w[4], int axis);
      longint acc;
      longint c;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        c = $signed(seg.pt[2*k + axis]);
        acc += round_frac(c * w[k]);
      end
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
      end
      return acc[COORD_W-1:0];
    endfunction

    // expand one accepted segment into its sampled points
    function void note_segment(segment_t seg);
      int           count;
      longint       t, s, s2, t2, d;
      longint       w[4];
      curve_point_t p;
      count = (seg.n > MAX_POINTS) ? MAX_POINTS : int'(seg.n);
      for (int i = 0; i < count; i++) begin
        if (count < 2) begin
          t = 0;
        end else begin
          d = count - 1;
          t = (longint'(i) * ONE_FIX + d / 2) / d;
        end
        s = ONE_FIX - t;
        s2 = round_frac(s * s);
        t2 = round_frac(t * t);
        w[0] = round_frac(s2 * s);
        w[1] = 3 * round_frac(s2 * t);
        w[2] = 3 * round_frac(s * t2);
        w[3] = round_frac(t2 * t);
        p.x = sample_axis(seg, w, 0);
        p.y = sample_axis(seg, w, 1);
        p.last = (i + 1 == count);
        pending_points.push_back(p);
      end
    endfunction

    function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
      curve_point_t e;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected point x=%h y=%h last=%0b with nothing pending", x, y, last);
        end
        return;
      end
      e = pending_points.pop_front();
      if (x !== e.x || y !== e.y || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("point mismatch: expected x=%h y=%h last=%0b, got x=%h y=%h last=%0b",
                   e.x, e.y, e.last, x, y, last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  curve_point_tracker tracker = new();
  bit                 sender_gaps = 1'b1;
  int                 idle_cycles = 0;

  cubic_bezier_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic segment_t fill_segment(logic [31:0] p0x, logic [31:0] p0y,
                                            logic [31:0] p1x, logic [31:0] p1y,
                                            logic [31:0] p2x, logic [31:0] p2y,
                                            logic [31:0] p3x, logic [31:0] p3y,
                                            logic [NUM_W-1:0] n);
    segment_t seg;
    seg.pt = {p3y, p3x, p2y, p2x, p1y, p1x, p0y, p0x};
    seg.n = n;
    return seg;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 15) return NUM_W'(1);
    if (r < 75) return NUM_W'($urandom_range(2, 8));
    if (r < 93) return NUM_W'($urandom_range(9, 40));
    return NUM_W'($urandom_range(41, 127));
  endfunction

  // offer one segment, note it once the transaction completes
  task automatic send_segment(input segment_t seg);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, seg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_segment(seg);
  endtask

  // receiver: random stalls, one long hold-off to back up the block
  initial begin
    int  stall;
    int  points_seen;
    bit  hold_done;
    bit  receiver_gaps;
    points_seen = 0;
    hold_done = 1'b0;
    receiver_gaps = 1'b1;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (points_seen % 50 == 0) begin
        receiver_gaps = $urandom_range(0, 1);
      end
      stall = receiver_gaps ? $urandom_range(0, 5) : 0;
      if (!hold_done && points_seen >= 40) begin
        stall = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tracker.check_point(out_tdata[31:0], out_tdata[63:32], out_tlast);
      points_seen++;
    end
  end

  // count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed segments
    send_segment(fill_segment('0, '0, '0, '0, '0, '0, '0, '0, 7'd0));
    send_segment(fill_segment(32'h0001_8000, 32'hfffe_4000, 32'h0010_0000, 32'h0020_0000,
                              32'hffe0_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                              7'd1));
    send_segment(fill_segment(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
                              32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 7'd2));
    send_segment(fill_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              7'd5));
    send_segment(fill_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              7'd7));
    send_segment(fill_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                              32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                              7'd9));
    send_segment(fill_segment(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                              32'hffff_ffff, 32'h0000_0001, 32'h0001_0000, 32'hffff_0000,
                              7'd3));
    send_segment(fill_segment(32'h0, 32'h0, 32'h0100_0000, 32'h0300_0000,
                              32'h0200_0000, 32'hfd00_0000, 32'h0300_0000, 32'h0,
                              7'd64));
    send_segment(fill_segment(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              7'd65));
    send_segment(fill_segment(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'h8765_4321,
                              32'h0000_ffff, 32'hffff_0001, 32'h7f00_0000, 32'h80ff_ffff,
                              7'd127));
    // zero samples still replace the held points
    send_segment(fill_segment(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h2,
                              32'h3, 32'h4, 32'h5, 32'h6, 7'd0));
    send_segment(fill_segment(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0,
                              32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 7'd1));
    send_segment(fill_segment(32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 7'd4));

    // random segments
    for (int k = 0; k < RAND_ITEMS; k++) begin
      segment_t seg;
      if (k % 32 == 0) begin
        sender_gaps = $urandom_range(0, 1);
      end
      for (int c = 0; c < 8; c++) begin
        seg.pt[c] = rand_coord();
      end
      seg.n = rand_count();
      send_segment(seg);
    end
    in_tvalid <= 1'b0;

    while (tracker.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cbs_pkg.sv
rtl/cbs_ctrl.sv
rtl/cbs_dp.sv
rtl/cubic_bezier_sampler.sv
dv/cubic_bezier_sampler_tb.sv
